// File: hdl/peak_clip_cross_filter_defines.svh
// ----------------------------------------------------------------------------
// Peak clip cross filter assertion macros
// Shared concurrent assertion forms for the filter RTL.
// ----------------------------------------------------------------------------
`ifndef PEAK_CLIP_CROSS_FILTER_DEFINES_SVH
`define PEAK_CLIP_CROSS_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcf same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcf next-cycle check failed");

`endif

// File: hdl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// Peak clip cross filter package
// Op codes, field widths and control types shared by the filter modules.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int OP_W = 2;
    localparam int RL_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_DRAIN = 2'd1,
        OP_FRAME = 2'd2
    } op_t;

    // Control handed from the window logic to the output stage
    typedef struct packed {
        logic emit;
        logic row_end;
    } res_ctrl_t;

endpackage

// File: hdl/peak_clip_cross_filter.sv
// Output: a result reaches the output register in the cycle after the word that causes it;
//   the value belongs to the previous row, so a pixel appears one row after it entered.
// Throughput: one word per cycle, set by the line store (one write and one prefetch
//   read per word); back-pressure from m_tready stalls the input directly.
// Reset: asynchronous, active low; clears column, row count, output valid and loads
//   row_length with 1024 (limited to MAX_ROW_LENGTH). Line stores are not cleared.
// ----------------------------------------------------------------------------
// Peak clip cross filter
// Streams a raster frame through a line store and clips every pixel to the
// largest of its edge neighbours above, below, left and right, zero outside the frame.
// ----------------------------------------------------------------------------
`include "peak_clip_cross_filter_defines.svh"

module peak_clip_cross_filter #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int PIXEL_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write: row_length
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcf_pkg::RL_W-1:0]             cfg_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,  // pixel_value
    input  logic [pcf_pkg::OP_W-1:0]             s_tuser,  // op
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]      m_tdata,  // filtered_value
    output logic                                 m_tlast   // row_end
);

    localparam int DATA_W   = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int AW       = $clog2(MAX_ROW_LENGTH);
    localparam int LW       = $clog2(MAX_ROW_LENGTH + 1);
    localparam int RL_RESET = (1024 > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : 1024;

    // Control state
    logic [LW-1:0]         row_length_reg;
    logic [LW-1:0]         row_length_next;
    logic [AW-1:0]         col_reg;
    logic [AW-1:0]         col_next;
    logic [1:0]            rows_reg;
    logic [1:0]            rows_next;

    // Window around the current column: center[c], upper[c], left (old center[c-1])
    logic [PIXEL_BITS-1:0] mid_reg;
    logic [PIXEL_BITS-1:0] mid_next;
    logic [PIXEL_BITS-1:0] up_reg;
    logic [PIXEL_BITS-1:0] up_next;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] left_next;

    // Copies of line store columns zero and one, needed right at a row wrap
    logic [PIXEL_BITS-1:0] cap0_c_reg;
    logic [PIXEL_BITS-1:0] cap0_c_next;
    logic [PIXEL_BITS-1:0] cap0_u_reg;
    logic [PIXEL_BITS-1:0] cap0_u_next;
    logic [PIXEL_BITS-1:0] cap1_c_reg;
    logic [PIXEL_BITS-1:0] cap1_c_next;
    logic [PIXEL_BITS-1:0] cap1_u_reg;
    logic [PIXEL_BITS-1:0] cap1_u_next;

    logic                  accept;
    logic                  step;
    logic                  frame;
    pcf_pkg::op_t          op;
    logic [PIXEL_BITS-1:0] pix;
    logic                  last;
    logic [PIXEL_BITS-1:0] right_c;
    logic [PIXEL_BITS-1:0] right_u;
    logic [PIXEL_BITS-1:0] nb_up;
    logic [PIXEL_BITS-1:0] nb_left;
    logic [PIXEL_BITS-1:0] nb_right;
    logic                  space;
    pcf_pkg::res_ctrl_t    ctrl;
    logic                  drain_end;
    logic                  restarted;

    // Line store entry: upper half is upper_line, lower half is center_line
    logic [2*PIXEL_BITS-1:0] ram_wd;
    logic [2*PIXEL_BITS-1:0] ram_rd;
    logic [AW-1:0]           ram_ra;

    logic [pcf_pkg::RL_W-1:0] cfg_len;

    // ------------------------------------------------------------------------
    // Configuration: clamp to 1..MAX_ROW_LENGTH
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_len         = cfg_data;
        row_length_next = row_length_reg;
        if (cfg_valid)
        begin
            if (cfg_len == '0)
            begin
                row_length_next = LW'(1);
            end
            else if (32'(cfg_len) > 32'(MAX_ROW_LENGTH))
            begin
                row_length_next = LW'(MAX_ROW_LENGTH);
            end
            else
            begin
                row_length_next = LW'(cfg_len);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------------
    assign s_tready = space;
    assign accept   = s_tvalid && s_tready;
    assign op       = pcf_pkg::op_t'(s_tuser);

    always_comb
    begin
        step  = 1'b0;
        frame = 1'b0;
        pix   = '0;
        case (op)
            pcf_pkg::OP_PIXEL:
            begin
                step = accept;
                pix  = s_tdata[PIXEL_BITS-1:0];
            end
            pcf_pkg::OP_DRAIN:
            begin
                // drain slot stands for a zero pixel below the frame
                step = accept;
            end
            pcf_pkg::OP_FRAME:
            begin
                frame = accept;
            end
            default:
            begin
                // unused code: drop the word
                step  = 1'b0;
                frame = 1'b0;
            end
        endcase
    end

    assign last = (LW'(col_reg) + LW'(1)) >= row_length_reg;

    // Right neighbour: column one sits in the copy registers, later columns
    // come from the prefetch issued while the previous word was processed.
    assign right_c = (col_reg == '0) ? cap1_c_reg : ram_rd[PIXEL_BITS-1:0];
    assign right_u = (col_reg == '0) ? cap1_u_reg : ram_rd[2*PIXEL_BITS-1:PIXEL_BITS];

    // Zero outside the frame
    assign nb_up    = (rows_reg >= 2'd2) ? up_reg : '0;
    assign nb_left  = (col_reg != '0) ? left_reg : '0;
    assign nb_right = last ? '0 : right_c;

    assign ctrl = '{emit: step && (rows_reg != 2'd0), row_end: last};

    // ------------------------------------------------------------------------
    // Line store: write the shifted column, prefetch two columns ahead
    // ------------------------------------------------------------------------
    assign ram_wd = {mid_reg, pix};
    assign ram_ra = AW'(LW'(col_reg) + LW'(2));

    pcf_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line_ram (
        .clk (clk),
        .we  (step),
        .wa  (col_reg),
        .wd  (ram_wd),
        .re  (step),
        .ra  (ram_ra),
        .rd  (ram_rd)
    );

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        cap0_c_next = cap0_c_reg;
        cap0_u_next = cap0_u_reg;
        cap1_c_next = cap1_c_reg;
        cap1_u_next = cap1_u_reg;
        if (step && (col_reg == '0))
        begin
            cap0_c_next = pix;
            cap0_u_next = mid_reg;
        end
        if (step && (col_reg == AW'(1)))
        begin
            cap1_c_next = pix;
            cap1_u_next = mid_reg;
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        mid_next  = mid_reg;
        up_next   = up_reg;
        left_next = left_reg;
        if (frame)
        begin
            // restart at column zero, reload the window from the copies
            col_next  = '0;
            rows_next = 2'd0;
            mid_next  = cap0_c_next;
            up_next   = cap0_u_next;
        end
        else if (step)
        begin
            if (last)
            begin
                col_next = '0;
                mid_next = cap0_c_next;
                up_next  = cap0_u_next;
                if (op == pcf_pkg::OP_DRAIN)
                begin
                    rows_next = 2'd0;
                end
                else if (rows_reg != 2'd2)
                begin
                    rows_next = rows_reg + 2'd1;
                end
            end
            else
            begin
                // advance: the right neighbour becomes the center
                col_next  = col_reg + AW'(1);
                mid_next  = right_c;
                up_next   = right_u;
                left_next = mid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= LW'(RL_RESET);
            col_reg        <= '0;
            rows_reg       <= 2'd0;
        end
        else
        begin
            row_length_reg <= row_length_next;
            col_reg        <= col_next;
            rows_reg       <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg    <= mid_next;
        up_reg     <= up_next;
        left_reg   <= left_next;
        cap0_c_reg <= cap0_c_next;
        cap0_u_reg <= cap0_u_next;
        cap1_c_reg <= cap1_c_next;
        cap1_u_reg <= cap1_u_next;
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    pcf_out_stage #(
        .PIXEL_BITS (PIXEL_BITS),
        .DATA_W     (DATA_W)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .ctrl     (ctrl),
        .mid      (mid_reg),
        .up       (nb_up),
        .down     (pix),
        .left     (nb_left),
        .right    (nb_right),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign drain_end = step && last && (op == pcf_pkg::OP_DRAIN);
    assign restarted = (col_reg == '0) && (rows_reg == 2'd0);

    `PCF_ASSERT_NOW(a_rows_range, clk, rst_n, 1'b1, rows_reg != 2'd3)
    `PCF_ASSERT_NEXT(a_frame_restart, clk, rst_n, frame, restarted)
    `PCF_ASSERT_NEXT(a_drain_close, clk, rst_n, drain_end, restarted)
    `PCF_ASSERT_NEXT(a_idle_hold, clk, rst_n, !step && !frame, $stable(col_reg) && $stable(rows_reg))

endmodule

// File: hdl/pcf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

// File: hdl/pcf_out_stage.sv
// ----------------------------------------------------------------------------
// Peak clip output stage
// Form the clipped value and hold it in the output register until taken.
// ----------------------------------------------------------------------------
module pcf_out_stage #(
    parameter int PIXEL_BITS = 16,
    parameter int DATA_W     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  pcf_pkg::res_ctrl_t      ctrl,
    input  logic [PIXEL_BITS-1:0]   mid,
    input  logic [PIXEL_BITS-1:0]   up,
    input  logic [PIXEL_BITS-1:0]   down,
    input  logic [PIXEL_BITS-1:0]   left,
    input  logic [PIXEL_BITS-1:0]   right,
    output logic                    space,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // [PIXEL_BITS-1:0] filtered_value
    output logic                    m_tlast    // row_end
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [PIXEL_BITS-1:0] value_reg;
    logic                  last_reg;
    logic [PIXEL_BITS-1:0] hi_a;
    logic [PIXEL_BITS-1:0] hi_b;
    logic [PIXEL_BITS-1:0] hi;
    logic [PIXEL_BITS-1:0] clipped;

    // Largest neighbour, then clip the center to it
    always_comb
    begin
        hi_a    = (up > down) ? up : down;
        hi_b    = (left > right) ? left : right;
        hi      = (hi_a > hi_b) ? hi_a : hi_b;
        clipped = (mid < hi) ? mid : hi;
    end

    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && ctrl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ctrl.emit)
        begin
            value_reg <= clipped;
            last_reg  <= ctrl.row_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_W'(value_reg);
    assign m_tlast  = last_reg;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Peak clip cross filter testbench
// Streams raster frames through the filter with random idling on both sides.
// Predicts every clipped pixel and checks it against the output stream, field by
// field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROW      = 1024;
    localparam int PIX_W        = 16;
    localparam int DATA_W       = ((PIX_W + 7) / 8) * 8;
    localparam int IDLE_PCT     = 16;
    localparam int SETTLE_PAD   = 4;
    localparam int RAND_ITEMS   = 590;
    localparam int LONG_LEN     = 40;
    localparam int LONG_ROWS    = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    // Op value with no meaning; the filter must ignore it
    localparam logic [pcf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [pcf_pkg::OP_W-1:0] op;
        logic [PIX_W-1:0]         pix;
    } word_t;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             row_end;
    } clipped_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [pcf_pkg::RL_W-1:0] cfg_data  = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [DATA_W-1:0]        s_tdata   = '0;   // pixel_value
    logic [pcf_pkg::OP_W-1:0] s_tuser   = '0;   // op
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DATA_W-1:0]        m_tdata;          // filtered_value
    logic                     m_tlast;          // row_end

    // Words waiting for the driver, and clipped pixels still owed by the filter
    word_t    pix_q[$];
    clipped_t clipped_q[$];

    // Shadow of the filter state: centre row, row above it, column and row count
    bit [PIX_W-1:0] cur_row   [MAX_ROW];
    bit [PIX_W-1:0] above_row [MAX_ROW];
    int             col_idx   = 0;
    int             rows_held = 0;
    int             row_len   = MAX_ROW;

    int errors = 0;
    int cycles = 0;
    bit quiet  = 1'b0;   // suppress all idling on both sides

    peak_clip_cross_filter #(
        .MAX_ROW_LENGTH(MAX_ROW),
        .PIXEL_BITS    (PIX_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: advance the shadow state by one accepted word and queue the
    // clipped pixel it releases, if any.
    // ------------------------------------------------------------------------
    task automatic clip_predict(input logic [pcf_pkg::OP_W-1:0] op,
                                input logic [PIX_W-1:0]         din);
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] mid;
        int               c;
        bit               row_done;
        if (op == pcf_pkg::OP_FRAME)
        begin
            col_idx   = 0;
            rows_held = 0;
        end
        else if (op != OP_UNUSED)
        begin
            // A drain stands for the zero row below the frame
            pix      = (op == pcf_pkg::OP_PIXEL) ? din : '0;
            c        = (col_idx >= MAX_ROW) ? MAX_ROW - 1 : col_idx;
            row_done = (c + 1 >= row_len);
            if (rows_held >= 1)
            begin
                // No row above the first row of a frame: treat it as zero
                up    = (rows_held >= 2) ? above_row[c] : '0;
                // Left neighbour has already moved to the upper store
                left  = (c > 0) ? above_row[c-1] : '0;
                right = (!row_done && c + 1 < MAX_ROW) ? cur_row[c+1] : '0;
                hi    = (up > pix) ? up : pix;
                if (left > hi)
                    hi = left;
                if (right > hi)
                    hi = right;
                mid = cur_row[c];
                clipped_q.push_back('{value: (mid < hi) ? mid : hi, row_end: row_done});
            end
            above_row[c] = cur_row[c];
            cur_row[c]   = pix;
            if (row_done)
            begin
                col_idx = 0;
                // A drain at the row end closes the frame
                if (op == pcf_pkg::OP_DRAIN)
                    rows_held = 0;
                else if (rows_held < 2)
                    rows_held++;
            end
            else
                col_idx = c + 1;
        end
    endtask

    task automatic note_failure(input string what);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued words on the slave side, idling at random.
    // Hold the word while tready is low; predict on acceptance.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        word_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                clip_predict(s_tuser, s_tdata[PIX_W-1:0]);
            if (!s_tvalid || s_tready)
            begin
                if (pix_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pix_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= DATA_W'(nxt.pix);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check every accepted output word against the oldest prediction,
    // and stall the master side at random.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        clipped_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (clipped_q.size() == 0)
                    note_failure($sformatf("unexpected word: value=%h row_end=%b",
                                           m_tdata, m_tlast));
                else
                begin
                    want = clipped_q.pop_front();
                    if (m_tdata[PIX_W-1:0] !== want.value || m_tlast !== want.row_end)
                        note_failure($sformatf(
                            "mismatch: value exp=%h got=%h, row_end exp=%b got=%b",
                            want.value, m_tdata[PIX_W-1:0], want.row_end, m_tlast));
                end
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("peak_clip_cross_filter regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [pcf_pkg::OP_W-1:0] op,
                              input logic [PIX_W-1:0]         pix);
        pix_q.push_back('{op: op, pix: pix});
    endtask

    // Bias toward small values and the extremes so ties and peaks are common
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PIX_W'($urandom_range(0, 7));
            5:       return PIX_W'(1) << $urandom_range(0, PIX_W - 1);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Wait until every queued word is taken and every prediction has arrived,
    // then pad for words that release no pixel but may still be in flight.
    // Sample at the falling edge so the driver's updates have landed.
    task automatic settle();
        while (pix_q.size() != 0 || s_tvalid || clipped_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_PAD) @(posedge clk);
    endtask

    // Write row_length; zero counts as one, anything past the store saturates
    task automatic write_row_len(input logic [pcf_pkg::RL_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        row_len   = (v == 0) ? 1 : (v > MAX_ROW) ? MAX_ROW : int'(v);
        cfg_valid <= 1'b0;
        cfg_data  <= pcf_pkg::RL_W'($urandom);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int len;
        int frames;
        int rows;
        int roll;
        int n_rand;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First row at the reset row length, with an ignored op in the middle
        queue_word(pcf_pkg::OP_FRAME, '0);
        queue_word(pcf_pkg::OP_PIXEL, 16'hFFFF);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0000);
        queue_word(OP_UNUSED, 16'hAAAA);
        queue_word(pcf_pkg::OP_PIXEL, 16'h8000);
        queue_word(pcf_pkg::OP_PIXEL, 16'h7FFF);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0001);
        settle();

        // Shrink the row under the column: the next word ends the row
        write_row_len(pcf_pkg::RL_W'(3));
        queue_word(pcf_pkg::OP_PIXEL, 16'h1234);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0005);
        queue_word(pcf_pkg::OP_PIXEL, 16'hFFFF);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0003);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0002);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0009);
        queue_word(pcf_pkg::OP_PIXEL, 16'h0004);
        repeat (3) queue_word(pcf_pkg::OP_DRAIN, 16'h5555);
        // Drain with no row held: store a zero, release nothing
        queue_word(pcf_pkg::OP_DRAIN, '0);
        settle();

        // Row length zero behaves as one
        write_row_len('0);
        queue_word(pcf_pkg::OP_FRAME, '0);
        queue_word(pcf_pkg::OP_PIXEL, 16'hFFFF);
        queue_word(pcf_pkg::OP_PIXEL, 16'h00FF);
        queue_word(pcf_pkg::OP_DRAIN, '0);
        settle();

        // Random frames, mostly short rows; each phase opens with a new frame
        // so a longer row never reads a store entry left unwritten
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                              : $urandom_range(1, 12);
            write_row_len((len == 1 && $urandom_range(0, 1) == 1) ? '0
                                                                   : pcf_pkg::RL_W'(len));
            quiet = ($urandom_range(0, 5) == 0);
            queue_word(pcf_pkg::OP_FRAME, '0);
            n_rand++;
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_word(pcf_pkg::OP_FRAME, '0);
                    n_rand++;
                end
                rows = $urandom_range(1, 5);
                repeat (rows * len)
                begin
                    roll = $urandom_range(0, 99);
                    // Noise: ignored ops, a stray frame start, drains inside a row
                    if (roll < 4)
                        queue_word(OP_UNUSED, PIX_W'($urandom));
                    if (roll == 4)
                    begin
                        queue_word(pcf_pkg::OP_FRAME, PIX_W'($urandom));
                        n_rand++;
                    end
                    if (roll >= 5 && roll < 8)
                        queue_word(pcf_pkg::OP_DRAIN, PIX_W'($urandom));
                    else
                        queue_word(pcf_pkg::OP_PIXEL, pick_pixel());
                    n_rand++;
                end
                // Flush the last row with a row of drains
                repeat (len) queue_word(pcf_pkg::OP_DRAIN, PIX_W'($urandom));
                n_rand += len;
            end
            settle();
        end

        // An oversize write saturates to the store depth, so the first pixels
        // stay inside one row. Then shrink under the column and run whole rows
        // without idling for a long back-to-back stretch.
        quiet = 1'b1;
        write_row_len('1);
        queue_word(pcf_pkg::OP_FRAME, '0);
        repeat (LONG_LEN) queue_word(pcf_pkg::OP_PIXEL, pick_pixel());
        settle();
        write_row_len(pcf_pkg::RL_W'(LONG_LEN));
        repeat (LONG_ROWS * LONG_LEN + 1) queue_word(pcf_pkg::OP_PIXEL, pick_pixel());
        repeat (LONG_LEN) queue_word(pcf_pkg::OP_DRAIN, '0);
        settle();
        quiet = 1'b0;

        repeat (SETTLE_PAD * 4) @(posedge clk);
        if (errors == 0)
            $display("peak_clip_cross_filter regression: pass");
        else
            $display("peak_clip_cross_filter regression: fail");
        $finish;
    end
endmodule
